// File: rtl/safs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_pkg
// Shared types and codes of the sprite animation frame selector.
// ----------------------------------------------------------------------------
package safs_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int TW = 64;

  typedef logic [2:0] func_t;
  localparam func_t FN_ADD   = 3'd0;
  localparam func_t FN_START = 3'd1;
  localparam func_t FN_STOP  = 3'd2;
  localparam func_t FN_SETC  = 3'd3;
  localparam func_t FN_SYNC  = 3'd4;
  localparam func_t FN_GET   = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_TW   = 2'd1;
  localparam logic [1:0] CFG_TH   = 2'd2;

  typedef enum logic [2:0] {
    SEL_SC_OLD,
    SEL_SC_NEW,
    SEL_SC_WHOLE,
    SEL_GF_RUN,
    SEL_GF_FLEN,
    SEL_GF_IDX,
    SEL_GF_MOD,
    SEL_GF_TILE
  } div_sel_t;

  typedef struct packed {
    logic     latch;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_cap;
    logic     tile_cap;
    logic     mul_start;
    logic     fin;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic cyc_same;
    logic cnt_zero;
  } dp_stat_t;

endpackage

// File: rtl/safs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module safs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/safs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module safs_div import safs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [TW-1:0] dividend,
  input  logic [TW-1:0] divisor,
  output logic          done,
  output logic [TW-1:0] quot,
  output logic [TW-1:0] rem
);

  localparam int CW = $clog2(TW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] quo_r, quo_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] dvs_r, dvs_nxt;
  logic [TW:0]   sh;
  logic [TW:0]   diff;

  always_comb begin
    sh       = {rem_r, quo_r[TW-1]};
    diff     = sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[TW]) begin
        rem_nxt = diff[TW-1:0];
        quo_nxt = {quo_r[TW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[TW-1:0];
        quo_nxt = {quo_r[TW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(TW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// File: rtl/safs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_ctrl
// Request sequencer: decodes the op code and steps the datapath.
// ----------------------------------------------------------------------------
module safs_ctrl import safs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  func_t    func,
  input  dp_stat_t stat,
  output logic     busy,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_WAIT = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_MULW = 9'b000100000,
    S_RD   = 9'b001000000,
    S_RDW  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  func_t      func_r, func_nxt;
  logic       out_valid_r;
  div_sel_t   sel;

  always_comb begin
    sel = SEL_SC_OLD;
    if (func_r == FN_SETC) begin
      case (step_r)
        3'd0:    sel = SEL_SC_OLD;
        3'd1:    sel = SEL_SC_NEW;
        default: sel = SEL_SC_WHOLE;
      endcase
    end else begin
      case (step_r)
        3'd0:    sel = SEL_GF_RUN;
        3'd1:    sel = SEL_GF_FLEN;
        3'd2:    sel = SEL_GF_IDX;
        3'd3:    sel = SEL_GF_MOD;
        default: sel = SEL_GF_TILE;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    func_nxt  = func_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = func;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        step_nxt = '0;
        if ((func_r == FN_SETC && !stat.cyc_same && !stat.cnt_zero) ||
            (func_r == FN_GET && !stat.cnt_zero)) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV:  state_nxt = S_WAIT;
      S_WAIT: begin
        if (stat.div_done) begin
          step_nxt = step_r + 3'd1;
          if (func_r == FN_SETC) begin
            state_nxt = (step_r == 3'd2) ? S_MUL : S_DIV;
          end else if (step_r == 3'd3) begin
            state_nxt = S_RD;
          end else if (step_r == 3'd4) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_MUL:  state_nxt = S_MULW;
      S_MULW: begin
        if (stat.mul_done) begin
          state_nxt = S_FIN;
        end
      end
      S_RD:   state_nxt = S_RDW;
      S_RDW:  state_nxt = S_DIV;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      func_r      <= FN_ADD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      func_r      <= func_nxt;
      out_valid_r <= (state_r == S_FIN);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.latch     = (state_r == S_IDLE) && start;
    cmd.div_start = (state_r == S_DIV);
    cmd.div_sel   = sel;
    cmd.div_cap   = (state_r == S_WAIT) && stat.div_done;
    cmd.tile_cap  = (state_r == S_RDW);
    cmd.mul_start = (state_r == S_MUL);
    cmd.fin       = (state_r == S_FIN);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/safs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_dp
// Datapath: timing state, frame table, shared divider, shift-add multiplier.
// ----------------------------------------------------------------------------
module safs_dp import safs_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  localparam int CW = $clog2(MAX_FRAMES + 1),
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat,
  input  func_t         in_func,
  input  logic [TW-1:0] in_now_time,
  input  logic [11:0]   in_tile_number,
  input  logic [TW-1:0] in_cycle_value,
  input  logic [TW-1:0] in_start_value,
  input  logic          in_stop_value,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [11:0]   cfg_data,
  output status_t       out_status,
  output logic [19:0]   out_pixel_x,
  output logic [23:0]   out_pixel_y,
  output logic [11:0]   out_pixel_w,
  output logic [11:0]   out_pixel_h,
  output logic [11:0]   out_tile_out,
  output logic          out_is_stopped,
  output logic [TW-1:0] out_cycle_out,
  output logic [TW-1:0] out_start_out,
  output logic [CW-1:0] out_count_out
);

  localparam int MCW = $clog2(TW);

  logic [7:0]    cols_r;
  logic [11:0]   tw_r, th_r;
  func_t         func_r;
  logic [TW-1:0] now_r, cyc_in_r, start_in_r;
  logic [11:0]   tile_in_r;
  logic          stop_in_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] cyc_r, cyc_nxt;
  logic [TW-1:0] start_r, start_nxt;
  logic          stop_r, stop_nxt;

  logic [TW-1:0] t0_r, t1_r, t2_r;
  logic [11:0]   tile_r;

  status_t       status_r, status_nxt;
  logic [19:0]   px_r, px_nxt;
  logic [23:0]   py_r, py_nxt;
  logic [11:0]   pw_r, pw_nxt;
  logic [11:0]   ph_r, ph_nxt;
  logic [11:0]   to_r, to_nxt;

  logic [TW-1:0] dvd, dvs, quot, rem;
  logic          div_done;
  logic [TW-1:0] cnt64;
  logic          full;
  logic          ram_we;
  logic [11:0]   ram_rdata;
  logic [7:0]    col;
  logic [11:0]   row;

  logic [TW-1:0]  mul_acc_r, mul_a_r, mul_b_r;
  logic [MCW-1:0] mul_cnt_r;
  logic           mul_busy_r, mul_done_r;

  assign cnt64 = TW'(cnt_r);
  assign full  = (cnt_r >= CW'(MAX_FRAMES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= '0;
      tw_r   <= '0;
      th_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: cols_r <= cfg_data[7:0];
        CFG_TW:   tw_r   <= cfg_data;
        CFG_TH:   th_r   <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r     <= in_func;
      now_r      <= in_now_time;
      cyc_in_r   <= in_cycle_value;
      start_in_r <= in_start_value;
      tile_in_r  <= in_tile_number;
      stop_in_r  <= in_stop_value;
    end
  end

  always_comb begin
    dvd = cyc_r;
    dvs = cnt64;
    case (cmd.div_sel)
      SEL_SC_OLD:   begin dvd = cyc_r;           dvs = cnt64;        end
      SEL_SC_NEW:   begin dvd = cyc_in_r;        dvs = cnt64;        end
      SEL_SC_WHOLE: begin dvd = start_r;         dvs = t0_r;         end
      SEL_GF_RUN:   begin dvd = now_r - start_r; dvs = cyc_r;        end
      SEL_GF_FLEN:  begin dvd = cyc_r;           dvs = cnt64;        end
      SEL_GF_IDX:   begin dvd = t0_r;            dvs = t1_r;         end
      SEL_GF_MOD:   begin dvd = t2_r;            dvs = cnt64;        end
      SEL_GF_TILE:  begin dvd = TW'(tile_r);     dvs = TW'(cols_r);  end
      default:      begin dvd = cyc_r;           dvs = cnt64;        end
    endcase
  end

  safs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.div_sel)
        SEL_SC_OLD:   t0_r <= quot;
        SEL_SC_NEW:   t1_r <= quot;
        SEL_SC_WHOLE: t2_r <= (t0_r == '0) ? '0 : quot;
        SEL_GF_RUN:   t0_r <= (cyc_r == '0) ? '0 : rem;
        SEL_GF_FLEN:  t1_r <= quot;
        SEL_GF_IDX:   t2_r <= (t1_r == '0 || stop_r) ? '0 : quot;
        SEL_GF_MOD:   t2_r <= rem;
        SEL_GF_TILE:  begin t0_r <= quot; t1_r <= rem; end
        default:      ;
      endcase
    end
    if (cmd.tile_cap) begin
      tile_r <= ram_rdata;
    end
  end

  // shift-add multiply of whole frames by the new frame length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else begin
      mul_done_r <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
        mul_cnt_r  <= '0;
      end else if (mul_busy_r) begin
        mul_cnt_r <= mul_cnt_r + 1'b1;
        if (mul_cnt_r == MCW'(TW - 1)) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
    if (cmd.mul_start) begin
      mul_acc_r <= '0;
      mul_a_r   <= t2_r;
      mul_b_r   <= t1_r;
    end else if (mul_busy_r) begin
      if (mul_b_r[0]) begin
        mul_acc_r <= mul_acc_r + mul_a_r;
      end
      mul_a_r <= {mul_a_r[TW-2:0], 1'b0};
      mul_b_r <= {1'b0, mul_b_r[TW-1:1]};
    end
  end

  assign ram_we = cmd.fin && (func_r == FN_ADD) && !full;

  safs_ram #(
    .WIDTH (12),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (tile_in_r),
    .raddr (t2_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign col = (cols_r == '0) ? '0 : t1_r[7:0];
  assign row = (cols_r == '0) ? '0 : t0_r[11:0];

  always_comb begin
    cnt_nxt    = cnt_r;
    cyc_nxt    = cyc_r;
    start_nxt  = start_r;
    stop_nxt   = stop_r;
    status_nxt = ST_OK;
    px_nxt     = '0;
    py_nxt     = '0;
    pw_nxt     = '0;
    ph_nxt     = '0;
    to_nxt     = '0;
    case (func_r)
      FN_ADD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      FN_START: begin
        if (stop_r) begin
          start_nxt = start_in_r;
        end
        stop_nxt = 1'b0;
      end
      FN_STOP: stop_nxt = 1'b1;
      FN_SETC: begin
        if (cyc_r != cyc_in_r) begin
          if (cnt_r == '0) begin
            status_nxt = ST_EMPTY;
            cyc_nxt    = '0;
            start_nxt  = '0;
          end else begin
            cyc_nxt   = cyc_in_r;
            start_nxt = (mul_acc_r > now_r) ? now_r - t1_r : mul_acc_r;
          end
        end
      end
      FN_SYNC: begin
        start_nxt = start_in_r;
        cyc_nxt   = cyc_in_r;
        stop_nxt  = stop_in_r;
      end
      FN_GET: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          px_nxt = 20'(col * tw_r);
          py_nxt = 24'(row * th_r);
          pw_nxt = tw_r;
          ph_nxt = th_r;
          to_nxt = tile_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      cyc_r   <= '0;
      start_r <= '0;
      stop_r  <= 1'b1;
    end else if (cmd.fin) begin
      cnt_r   <= cnt_nxt;
      cyc_r   <= cyc_nxt;
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
    end
    if (cmd.fin) begin
      status_r <= status_nxt;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      pw_r     <= pw_nxt;
      ph_r     <= ph_nxt;
      to_r     <= to_nxt;
    end
  end

  always_comb begin
    stat.div_done = div_done;
    stat.mul_done = mul_done_r;
    stat.cyc_same = (cyc_r == cyc_in_r);
    stat.cnt_zero = (cnt_r == '0);
  end

  assign out_status     = status_r;
  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_pixel_w    = pw_r;
  assign out_pixel_h    = ph_r;
  assign out_tile_out   = to_r;
  assign out_is_stopped = stop_r;
  assign out_cycle_out  = cyc_r;
  assign out_start_out  = start_r;
  assign out_count_out  = cnt_r;

endmodule

// File: rtl/sprite_animation_frame_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_animation_frame_select
// Sprite animation timing and frame lookup on a sprite sheet.
//
// Requests enter on start/in_*; a request is taken when start is high and
// busy is low. Each request gives one result, shown for one cycle with
// out_valid high; the receiver cannot stall, so results are never held.
// Add, start, stop, sync, unused codes and requests that skip the arithmetic
// go straight from decode to finish. Set cycle makes 3 passes on the shared
// 64-bit divider and one on the shift-add multiplier. Get frame takes 5
// divider passes plus a table read. The divider gives one quotient bit per
// cycle while busy; one request is in flight at a time.
// The cfg channel (cfg_valid/cfg_ready, always ready) writes sheet columns,
// tile width and tile height; write only while idle.
// Reset clears the frame count, cycle and start time and sets the stopped
// flag; the frame table holds no defined value until written.
// ----------------------------------------------------------------------------
module sprite_animation_frame_select import safs_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  localparam int CW = $clog2(MAX_FRAMES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    in_func,
  input  logic [63:0]   in_now_time,
  input  logic [11:0]   in_tile_number,
  input  logic [63:0]   in_cycle_value,
  input  logic [63:0]   in_start_value,
  input  logic          in_stop_value,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [19:0]   out_pixel_x,
  output logic [23:0]   out_pixel_y,
  output logic [11:0]   out_pixel_w,
  output logic [11:0]   out_pixel_h,
  output logic [11:0]   out_tile_out,
  output logic          out_is_stopped,
  output logic [63:0]   out_cycle_out,
  output logic [63:0]   out_start_out,
  output logic [CW-1:0] out_count_out,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [11:0]   cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  safs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_func),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  safs_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (in_func),
    .in_now_time    (in_now_time),
    .in_tile_number (in_tile_number),
    .in_cycle_value (in_cycle_value),
    .in_start_value (in_start_value),
    .in_stop_value  (in_stop_value),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_status     (out_status),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_w    (out_pixel_w),
    .out_pixel_h    (out_pixel_h),
    .out_tile_out   (out_tile_out),
    .out_is_stopped (out_is_stopped),
    .out_cycle_out  (out_cycle_out),
    .out_start_out  (out_start_out),
    .out_count_out  (out_count_out)
  );

endmodule
